[hw/rtl/fad_pkg.sv]
// Package for the frequency analysis decipher block.
// Holds the command and state codes, the control bundle and the letter decoder.
// No dependencies.
`default_nettype none
package fad_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int NUM_LETTERS = 26;
	localparam int IDX_W       = 5;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
	localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_LETTERS - 1);
	localparam logic [7:0]             LOWER_A   = 8'd97;
	localparam logic [7:0]             UPPER_A   = 8'd65;
	localparam logic [7:0]             CASE_GAP  = 8'd32;
	localparam logic [7:0]             LOWER_END = 8'd123;
	localparam logic [7:0]             UPPER_END = 8'd91;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_LOAD   = 3'd1,
		CMD_COUNT  = 3'd2,
		CMD_SORT   = 3'd3,
		CMD_DECODE = 3'd4
	} cmd_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LOAD,
		ST_COUNT,
		ST_SORT_A,
		ST_SORT_M,
		ST_DEC_RANK,
		ST_DEC_OUT
	} state_t;

	// sequencer strobes toward the datapath
	typedef struct packed {
		logic             ready;
		logic             do_clear;
		logic             do_load;
		logic             do_count;
		logic             sort_latch;
		logic             sort_step;
		logic             sort_wr;
		logic             dec_rank;
		logic             dec_out;
		logic [IDX_W-1:0] a_idx;
		logic [IDX_W-1:0] m_idx;
	} ctrl_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} letter_t;

	// letter index of a byte, case folded; hit low for non-letters
	function automatic letter_t letter_of(input logic [7:0] b);
		letter_t    r;
		logic [7:0] d;
		r.hit = 1'b0;
		r.idx = '0;
		if (b >= LOWER_A && b < LOWER_END) begin
			d     = b - LOWER_A;
			r.hit = 1'b1;
			r.idx = d[IDX_W-1:0];
		end else if (b >= UPPER_A && b < UPPER_END) begin
			d     = b + CASE_GAP - LOWER_A;
			r.hit = 1'b1;
			r.idx = d[IDX_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/fad_rank_unit.sv]
// Shared compare unit for the sort: one count compare per cycle while step is high, rank accumulator.
// Depends on fad_pkg.
`default_nettype none
module fad_rank_unit import fad_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   latch,
	input  wire logic                   step,
	input  wire logic [COUNT_WIDTH-1:0] cnt_rd,
	input  wire logic [IDX_W-1:0]       a_idx,
	input  wire logic [IDX_W-1:0]       m_idx,
	output logic      [IDX_W-1:0]       rank_next
);

	logic [COUNT_WIDTH-1:0] ca_q;
	logic [IDX_W-1:0]       rank_q;
	logic                   below;

	// letter m ranks below letter a: smaller count, or equal count and earlier
	always_comb begin
		below     = (cnt_rd < ca_q) || ((cnt_rd == ca_q) && (m_idx < a_idx));
		rank_next = rank_q + IDX_W'(below);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (latch) begin
			rank_q <= '0;
		end else if (step) begin
			rank_q <= rank_next;
		end
	end

	// count of the letter being ranked
	always_ff @(posedge clk) begin
		if (latch) begin
			ca_q <= cnt_rd;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/fad_ctrl.sv]
// Sequencer: command dispatch, sort loop counters, decode steps.
// Depends on fad_pkg.
`default_nettype none
module fad_ctrl import fad_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [2:0] req_cmd,
	input  wire logic       out_busy,
	output ctrl_t           ctl
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] a_q, m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d        = state_q;
		ctl            = '0;
		ctl.a_idx      = a_q;
		ctl.m_idx      = m_q;
		unique case (state_q)
			ST_IDLE: begin
				ctl.ready = 1'b1;
				if (req_valid) begin
					unique case (req_cmd)
						CMD_CLEAR:  state_d = ST_CLEAR;
						CMD_LOAD:   state_d = ST_LOAD;
						CMD_COUNT:  state_d = ST_COUNT;
						CMD_SORT:   state_d = ST_SORT_A;
						CMD_DECODE: state_d = ST_DEC_RANK;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				ctl.do_clear = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_LOAD: begin
				ctl.do_load = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_COUNT: begin
				ctl.do_count = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_SORT_A: begin
				ctl.sort_latch = 1'b1;
				state_d        = ST_SORT_M;
			end
			ST_SORT_M: begin
				ctl.sort_step = 1'b1;
				if (m_q == LAST_IDX) begin
					ctl.sort_wr = 1'b1;
					state_d     = (a_q == LAST_IDX) ? ST_IDLE : ST_SORT_A;
				end
			end
			ST_DEC_RANK: begin
				ctl.dec_rank = 1'b1;
				state_d      = ST_DEC_OUT;
			end
			ST_DEC_OUT: begin
				if (!out_busy) begin
					ctl.dec_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sort loop counters: a over letters, m over compared letters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			m_q <= '0;
		end else begin
			if (ctl.ready) begin
				a_q <= '0;
			end else if (ctl.sort_wr) begin
				a_q <= a_q + IDX_W'(1);
			end
			if (ctl.sort_latch) begin
				m_q <= '0;
			end else if (ctl.sort_step) begin
				m_q <= m_q + IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/frequency_analysis_decipher.sv]
// Top level of the frequency analysis decipher: letter counts, rank map, key table.
// Depends on fad_pkg, fad_ctrl and fad_rank_unit.
//
// channel | dir | tdata fields (low bit up)                      | notes
// s_      | in  | command[2:0] key_rank[7:3] data_byte[15:8]      | one command per request
// m_      | out | plain_byte[7:0]                                | only decode gives a request
//
// Clear, load key and count each act in their own sequencer state, then return to idle.
// Decode reads the rank, then waits until the output register is free before writing it.
// Sort ranks every letter in turn: the rank unit does one count compare a cycle.
// Reset zeroes counts and keys and sets the rank map to alphabet order.
// s_tready is high only while the sequencer is idle.
`default_nettype none
module frequency_analysis_decipher import fad_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // command[2:0], key_rank[7:3], data_byte[15:8]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata    // plain_byte[7:0]
);

	ctrl_t                  ctl;
	logic                   accept;
	logic [IDX_W-1:0]       rank_q;
	logic [7:0]             byte_q;
	logic [COUNT_WIDTH-1:0] counts_q [NUM_LETTERS];
	logic [IDX_W-1:0]       ltr_q    [NUM_LETTERS];
	logic [7:0]             key_q    [NUM_LETTERS];
	letter_t                lt;
	logic [IDX_W-1:0]       rd_idx;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [IDX_W-1:0]       rank_next;
	logic [IDX_W-1:0]       dec_rank_q;
	logic                   out_valid_q;
	logic [7:0]             out_data_q;

	assign s_tready = ctl.ready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	fad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_cmd   (s_tdata[2:0]),
		.out_busy  (out_valid_q && !m_tready),
		.ctl       (ctl)
	);

	// request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			rank_q <= s_tdata[7:3];
			byte_q <= s_tdata[15:8];
		end
	end

	assign lt = letter_of(byte_q);

	// single count read port, shared by count and sort
	always_comb begin
		if (ctl.sort_step) begin
			rd_idx = ctl.m_idx;
		end else if (ctl.sort_latch) begin
			rd_idx = ctl.a_idx;
		end else begin
			rd_idx = lt.idx;
		end
		cnt_rd = counts_q[rd_idx];
	end

	fad_rank_unit u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.latch     (ctl.sort_latch),
		.step      (ctl.sort_step),
		.cnt_rd    (cnt_rd),
		.a_idx     (ctl.a_idx),
		.m_idx     (ctl.m_idx),
		.rank_next (rank_next)
	);

	// letter counts, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++) counts_q[i] <= '0;
		end else if (ctl.do_clear) begin
			for (int i = 0; i < NUM_LETTERS; i++) counts_q[i] <= '0;
		end else if (ctl.do_count && lt.hit && cnt_rd != CNT_MAX) begin
			counts_q[lt.idx] <= cnt_rd + COUNT_WIDTH'(1);
		end
	end

	// letter to rank map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++) ltr_q[i] <= IDX_W'(i);
		end else if (ctl.do_clear) begin
			for (int i = 0; i < NUM_LETTERS; i++) ltr_q[i] <= IDX_W'(i);
		end else if (ctl.sort_wr) begin
			ltr_q[ctl.a_idx] <= rank_next;
		end
	end

	// key bytes by rank; ranks past the last letter are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++) key_q[i] <= '0;
		end else if (ctl.do_load && rank_q <= LAST_IDX) begin
			key_q[rank_q] <= byte_q;
		end
	end

	// decode step one: rank of the letter
	always_ff @(posedge clk) begin
		if (ctl.dec_rank) begin
			dec_rank_q <= ltr_q[lt.idx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.dec_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dec_out) begin
			out_data_q <= lt.hit ? key_q[dec_rank_q] : byte_q;
		end
	end

	// a new result only comes from the decode output step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl.dec_out))
		else $error("result without decode");

	// the rank map only holds ranks of real letters
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dec_out && lt.hit |-> dec_rank_q <= LAST_IDX)
		else $error("decode rank out of range");

	// a saturated count stays saturated after a count request
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_count && lt.hit && cnt_rd == CNT_MAX |=> counts_q[$past(lt.idx)] == CNT_MAX)
		else $error("count wrapped");

	// the output register is never overwritten while a result waits
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dec_out |-> !out_valid_q || m_tready)
		else $error("result overwritten");

endmodule
`default_nettype wire

[bench/fad_checker.sv]
// Checker for the frequency analysis decipher: watches both stream channels,
// keeps its own letter tallies, rank map and key table, and compares plain bytes.
// Depends on fad_pkg.
module fad_checker import fad_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,   // command[2:0], key_rank[7:3], data_byte[15:8]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,   // plain_byte[7:0]
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [COUNT_WIDTH-1:0] tally    [NUM_LETTERS];
	logic [IDX_W-1:0]       rank_of  [NUM_LETTERS];
	logic [7:0]             key_table[NUM_LETTERS];
	logic [7:0]             plain_due[$];
	int                     fails = 0;

	assign fail_count = fails;

	task automatic report(input string msg);
		$display("[%0t] decipher mismatch: %s", $time, msg);
		fails++;
	endtask

	// case-folded letter index, -1 for anything that is not a letter
	function automatic int letter_index(input logic [7:0] b);
		if (b >= LOWER_A && b < LOWER_END)
			return int'(b - LOWER_A);
		if (b >= UPPER_A && b < UPPER_END)
			return int'(b - UPPER_A);
		return -1;
	endfunction

	// stable ascending order: rank = letters with a lower tally, or equal and earlier
	task automatic rerank();
		int rnk;
		for (int a = 0; a < NUM_LETTERS; a++) begin
			rnk = 0;
			for (int m = 0; m < NUM_LETTERS; m++)
				if (tally[m] < tally[a] || (tally[m] == tally[a] && m < a))
					rnk++;
			rank_of[a] = IDX_W'(rnk);
		end
	endtask

	task automatic identity_ranks();
		for (int i = 0; i < NUM_LETTERS; i++)
			rank_of[i] = IDX_W'(i);
	endtask

	task automatic apply_command(input logic [2:0] cmd, input logic [IDX_W-1:0] rank,
			input logic [7:0] b);
		int ltr;
		ltr = letter_index(b);
		case (cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < NUM_LETTERS; i++)
					tally[i] = '0;
				identity_ranks();
			end
			CMD_LOAD: begin
				// ranks past the last letter are dropped
				if (rank < NUM_LETTERS)
					key_table[rank] = b;
			end
			CMD_COUNT: begin
				// tallies saturate at all ones
				if (ltr >= 0 && tally[ltr] != CNT_MAX)
					tally[ltr] = tally[ltr] + 1'b1;
			end
			CMD_SORT: begin
				rerank();
			end
			CMD_DECODE: begin
				plain_due.push_back(ltr >= 0 ? key_table[rank_of[ltr]] : b);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_plain(input logic [7:0] got);
		logic [7:0] want;
		if (plain_due.size() == 0) begin
			report($sformatf("plain_byte %02h with no decode outstanding", got));
		end else begin
			want = plain_due.pop_front();
			if (got !== want)
				report($sformatf("plain_byte %02h, want %02h", got, want));
		end
	endtask

	// results are checked before a request in the same cycle is applied
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++) begin
				tally[i]     = '0;
				key_table[i] = '0;
			end
			identity_ranks();
			plain_due.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_plain(m_tdata);
			if (s_tvalid && s_tready)
				apply_command(s_tdata[2:0], s_tdata[7:3], s_tdata[15:8]);
			pending = plain_due.size();
		end
	end

endmodule

[bench/tb.sv]
// Testbench top for frequency_analysis_decipher: clock, reset, command stream,
// output backpressure and the verdict. Depends on fad_pkg, the block and fad_checker.
module tb import fad_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT        = 1_000_000;
	localparam int RANDOM_ITEMS     = 400;
	localparam int HEAVY_COUNTS     = 24;
	localparam int RX_HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES     = 750;
	localparam int PRESSURE_SESSION = 2;
	localparam int DRAIN_SESSION    = 4;
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // command[2:0], key_rank[7:3], data_byte[15:8]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // plain_byte[7:0]

	int fail_count;
	int pending;
	int cycle_count = 0;
	int sent = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_req = 1'b0;

	frequency_analysis_decipher u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fad_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("frequency_analysis_decipher regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] letter_byte(input int idx, input bit upper);
		return (upper ? UPPER_A : LOWER_A) + 8'(idx);
	endfunction

	// mostly letters, skewed toward the front of the alphabet, some raw bytes
	function automatic logic [7:0] text_byte();
		int skew;
		if ($urandom_range(4, 0) == 0)
			return 8'($urandom);
		skew = ($urandom_range(NUM_LETTERS - 1, 0) * $urandom_range(NUM_LETTERS - 1, 0))
			/ (NUM_LETTERS - 1);
		return letter_byte(skew, 1'($urandom_range(1, 0)));
	endfunction

	// one request; called and returns at a falling edge
	task automatic send_req(input logic [2:0] cmd, input logic [IDX_W-1:0] rank,
			input logic [7:0] data);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(3, 0);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {data, rank, cmd};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_noise();
		send_req(3'($urandom), 5'($urandom), 8'($urandom));
	endtask

	// sender pauses until every decode has come back
	task automatic wait_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// optional clear, key loads, a burst of text to count, sort, then a burst to decode, with noise mixed into both bursts
	task automatic run_session(input int idx);
		int n_text;
		tx_steady = ($urandom_range(3, 0) == 0) || idx == PRESSURE_SESSION;
		rx_steady = ($urandom_range(3, 0) == 0);
		n_text    = $urandom_range(30, 12);
		if ($urandom_range(1, 0))
			send_req(CMD_CLEAR, 5'($urandom), 8'($urandom));
		repeat ($urandom_range(8, 2))
			send_req(CMD_LOAD, 5'($urandom), 8'($urandom));
		repeat (n_text)
			if ($urandom_range(9, 0) == 0)
				send_noise();
			else
				send_req(CMD_COUNT, 5'($urandom), text_byte());
		send_req(CMD_SORT, 5'($urandom), 8'($urandom));
		if (idx == PRESSURE_SESSION)
			rx_hold_req = 1'b1;
		repeat ($urandom_range(20, 8))
			if ($urandom_range(9, 0) == 0)
				send_noise();
			else
				send_req(CMD_DECODE, 5'($urandom), text_byte());
		if (idx == DRAIN_SESSION)
			wait_results();
	endtask

	// output side: random stalls per request, one long hold when asked
	initial begin : receiver
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			stall = rx_steady ? 0 : $urandom_range(3, 0);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int session;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset keys, rank bounds, letter boundaries, ties, unknown commands
		send_req(CMD_DECODE, 5'd0, letter_byte(0, 1'b0));
		send_req(CMD_LOAD, 5'd0, 8'hff);
		send_req(CMD_LOAD, 5'd25, 8'h80);
		send_req(CMD_LOAD, 5'd1, 8'h01);
		send_req(CMD_LOAD, 5'd31, 8'h77);
		send_req(CMD_LOAD, 5'd26, 8'h77);
		send_req(CMD_DECODE, 5'd31, letter_byte(0, 1'b0));
		send_req(CMD_DECODE, 5'd0, letter_byte(25, 1'b1));
		send_req(CMD_DECODE, 5'd0, 8'h00);
		send_req(CMD_DECODE, 5'd0, 8'hff);
		send_req(CMD_DECODE, 5'd0, UPPER_A - 8'd1);
		send_req(CMD_DECODE, 5'd0, UPPER_END);
		send_req(CMD_DECODE, 5'd0, LOWER_A - 8'd1);
		send_req(CMD_DECODE, 5'd0, LOWER_END);
		send_req(CMD_COUNT, 5'd0, letter_byte(25, 1'b1));
		send_req(CMD_COUNT, 5'd0, letter_byte(25, 1'b0));
		send_req(CMD_COUNT, 5'd0, letter_byte(1, 1'b1));
		send_req(CMD_COUNT, 5'd0, LOWER_END);
		send_req(CMD_COUNT, 5'd0, LOWER_A - 8'd1);
		send_req(CMD_SORT, 5'd0, 8'h00);
		send_req(CMD_DECODE, 5'd0, letter_byte(25, 1'b0));
		send_req(CMD_DECODE, 5'd0, letter_byte(0, 1'b1));
		send_req(CMD_UNUSED_FIRST, 5'd0, letter_byte(0, 1'b0));
		send_req(CMD_UNUSED_LAST, 5'd31, 8'hff);
		send_req(CMD_CLEAR, 5'd0, 8'h00);
		send_req(CMD_DECODE, 5'd0, letter_byte(1, 1'b0));

		// one heavy letter, mixed case, back to back
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_req(CMD_LOAD, 5'd25, 8'h5a);
		repeat (HEAVY_COUNTS)
			send_req(CMD_COUNT, 5'($urandom), letter_byte(16, 1'($urandom_range(1, 0))));
		send_req(CMD_COUNT, 5'd0, letter_byte(4, 1'b0));
		send_req(CMD_SORT, 5'd0, 8'h00);
		send_req(CMD_DECODE, 5'd0, letter_byte(16, 1'b1));
		send_req(CMD_DECODE, 5'd0, letter_byte(4, 1'b0));
		send_req(CMD_DECODE, 5'd0, letter_byte(0, 1'b0));
		send_req(CMD_CLEAR, 5'd0, 8'h00);

		// random sessions
		sent    = 0;
		session = 0;
		while (sent < RANDOM_ITEMS) begin
			run_session(session);
			session++;
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("frequency_analysis_decipher regression: pass");
		else
			$display("frequency_analysis_decipher regression: fail");
		$finish;
	end

endmodule
